FILE: rtl/mfbfs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfbfs_pkg
// shared constants, op codes and interface structs of the max flow core
// ---------------------------------------------------------------------------
package mfbfs_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int NUM_W     = 7;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int CAP_WIDTH = 16;
    localparam int STORE_W   = CAP_WIDTH + 8;
    localparam int FLOW_W    = STORE_W + 1;
    localparam int RES_W     = FLOW_W + 2;
    localparam int LOW_W     = 31;
    localparam int ACC_W     = 32;
    localparam int OUT_W     = 30;

    localparam logic signed [LOW_W-1:0] BIG_BOUND = LOW_W'(1000000000);
    localparam logic [STORE_W-1:0]      STORE_MAX = {STORE_W{1'b1}};
    localparam logic [OUT_W-1:0]        OUT_MAX   = {OUT_W{1'b1}};

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_CLEAR    = 5'd1;
    localparam logic [4:0] OP_ACCEPT   = 5'd2;
    localparam logic [4:0] OP_LD_RD    = 5'd3;
    localparam logic [4:0] OP_LD_WR    = 5'd4;
    localparam logic [4:0] OP_S_INIT   = 5'd5;
    localparam logic [4:0] OP_S_POP    = 5'd6;
    localparam logic [4:0] OP_S_U      = 5'd7;
    localparam logic [4:0] OP_S_RD     = 5'd8;
    localparam logic [4:0] OP_S_CHK    = 5'd9;
    localparam logic [4:0] OP_A_INIT   = 5'd10;
    localparam logic [4:0] OP_A_SKIP   = 5'd11;
    localparam logic [4:0] OP_A_RD     = 5'd12;
    localparam logic [4:0] OP_A_START  = 5'd13;
    localparam logic [4:0] OP_P_RD     = 5'd14;
    localparam logic [4:0] OP_P_CHK    = 5'd15;
    localparam logic [4:0] OP_P_PAR    = 5'd16;
    localparam logic [4:0] OP_U_START  = 5'd17;
    localparam logic [4:0] OP_U_RD     = 5'd18;
    localparam logic [4:0] OP_U_W1     = 5'd19;
    localparam logic [4:0] OP_U_W2     = 5'd20;
    localparam logic [4:0] OP_U_PAR    = 5'd21;
    localparam logic [4:0] OP_SUM_INIT = 5'd22;
    localparam logic [4:0] OP_SUM_RD   = 5'd23;
    localparam logic [4:0] OP_SUM_ACC  = 5'd24;
    localparam logic [4:0] OP_EMIT     = 5'd25;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic last;
        logic q_empty;
        logic sink_seen;
        logic x_end;
        logic x_seen;
        logic edge_ok;
        logic par_src;
        logic out_busy;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/mfbfs_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfbfs_ctrl
// sequencer for edge load, breadth-first search, augmentation and sum
// ---------------------------------------------------------------------------
module mfbfs_ctrl import mfbfs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_LD_RD   = 5'd2;
    localparam logic [4:0] S_LD_WR   = 5'd3;
    localparam logic [4:0] S_S_INIT  = 5'd4;
    localparam logic [4:0] S_S_POP   = 5'd5;
    localparam logic [4:0] S_S_U     = 5'd6;
    localparam logic [4:0] S_S_RD    = 5'd7;
    localparam logic [4:0] S_S_CHK   = 5'd8;
    localparam logic [4:0] S_A_RD    = 5'd9;
    localparam logic [4:0] S_A_CHK   = 5'd10;
    localparam logic [4:0] S_P_RD    = 5'd11;
    localparam logic [4:0] S_P_CHK   = 5'd12;
    localparam logic [4:0] S_P_PAR   = 5'd13;
    localparam logic [4:0] S_U_START = 5'd14;
    localparam logic [4:0] S_U_RD    = 5'd15;
    localparam logic [4:0] S_U_W1    = 5'd16;
    localparam logic [4:0] S_U_W2    = 5'd17;
    localparam logic [4:0] S_U_PAR   = 5'd18;
    localparam logic [4:0] S_SUM_RD  = 5'd19;
    localparam logic [4:0] S_SUM_ACC = 5'd20;
    localparam logic [4:0] S_EMIT    = 5'd21;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = S_LD_RD;
                end
            end
            S_LD_RD: begin
                o_cmd.op = OP_LD_RD;
                n_state  = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.op = OP_LD_WR;
                n_state  = i_stat.last ? S_S_INIT : S_IDLE;
            end
            S_S_INIT: begin
                o_cmd.op = OP_S_INIT;
                n_state  = S_S_POP;
            end
            S_S_POP: begin
                if (i_stat.sink_seen) begin
                    o_cmd.op = OP_A_INIT;
                    n_state  = S_A_RD;
                end else if (i_stat.q_empty) begin
                    o_cmd.op = OP_SUM_INIT;
                    n_state  = S_SUM_RD;
                end else begin
                    o_cmd.op = OP_S_POP;
                    n_state  = S_S_U;
                end
            end
            S_S_U: begin
                o_cmd.op = OP_S_U;
                n_state  = S_S_RD;
            end
            S_S_RD: begin
                o_cmd.op = OP_S_RD;
                n_state  = S_S_CHK;
            end
            S_S_CHK: begin
                o_cmd.op = OP_S_CHK;
                n_state  = i_stat.x_end ? S_S_POP : S_S_RD;
            end
            S_A_RD: begin
                if (i_stat.x_end) begin
                    n_state = S_S_INIT;
                end else if (!i_stat.x_seen) begin
                    o_cmd.op = OP_A_SKIP;
                end else begin
                    o_cmd.op = OP_A_RD;
                    n_state  = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_stat.edge_ok) begin
                    o_cmd.op = OP_A_START;
                    n_state  = S_P_RD;
                end else begin
                    o_cmd.op = OP_A_SKIP;
                    n_state  = S_A_RD;
                end
            end
            S_P_RD: begin
                o_cmd.op = OP_P_RD;
                n_state  = S_P_CHK;
            end
            S_P_CHK: begin
                o_cmd.op = OP_P_CHK;
                n_state  = i_stat.par_src ? S_U_START : S_P_PAR;
            end
            S_P_PAR: begin
                o_cmd.op = OP_P_PAR;
                n_state  = S_P_RD;
            end
            S_U_START: begin
                o_cmd.op = OP_U_START;
                n_state  = S_U_RD;
            end
            S_U_RD: begin
                o_cmd.op = OP_U_RD;
                n_state  = S_U_W1;
            end
            S_U_W1: begin
                o_cmd.op = OP_U_W1;
                n_state  = S_U_W2;
            end
            S_U_W2: begin
                o_cmd.op = OP_U_W2;
                n_state  = i_stat.par_src ? S_A_RD : S_U_PAR;
            end
            S_U_PAR: begin
                o_cmd.op = OP_U_PAR;
                n_state  = S_U_RD;
            end
            S_SUM_RD: begin
                if (i_stat.x_end) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_SUM_RD;
                    n_state  = S_SUM_ACC;
                end
            end
            S_SUM_ACC: begin
                o_cmd.op = OP_SUM_ACC;
                n_state  = S_SUM_RD;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/mfbfs_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mfbfs_dp
// graph stores, search queue, parent table, path registers and output stage
// ---------------------------------------------------------------------------
module mfbfs_dp import mfbfs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_stat                      o_stat,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [NUM_W-1:0]      i_cfg_wr_data,
    input  wire logic [NUM_W-1:0]      i_edge_from,
    input  wire logic [NUM_W-1:0]      i_edge_to,
    input  wire logic [CAP_WIDTH-1:0]  i_capacity,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [OUT_W-1:0]           o_max_flow
);

    logic [STORE_W-1:0]       cap_mem  [2**ADDR_W];
    logic [FLOW_W-1:0]        flow_mem [2**ADDR_W];
    logic                     adj_mem  [2**ADDR_W];
    logic [IDX_W-1:0]         par_mem  [MAX_NODES];
    logic [IDX_W-1:0]         q_mem    [MAX_NODES];

    logic [STORE_W-1:0]       r_cap_rd;
    logic signed [FLOW_W-1:0] r_flow_rd;
    logic                     r_adj_rd1;
    logic                     r_adj_rd2;
    logic [IDX_W-1:0]         r_par_rd;
    logic [IDX_W-1:0]         r_q_rd;

    logic [NUM_W-1:0]         r_node_count;
    logic [IDX_W-1:0]         r_a;
    logic [IDX_W-1:0]         r_b;
    logic                     r_ok;
    logic [CAP_WIDTH-1:0]     r_cap_in;
    logic                     r_last;
    logic [ADDR_W-1:0]        r_clr;
    logic [MAX_NODES-1:0]     r_seen;
    logic [NUM_W-1:0]         r_head;
    logic [NUM_W-1:0]         r_tail;
    logic [IDX_W-1:0]         r_u;
    logic [IDX_W-1:0]         r_x;
    logic [IDX_W-1:0]         r_cur;
    logic [IDX_W-1:0]         r_par;
    logic signed [LOW_W-1:0]  r_low;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_max_flow;

    logic [IDX_W-1:0]         sink;
    logic [ADDR_W-1:0]        cap_ra;
    logic [ADDR_W-1:0]        flow_ra;
    logic [ADDR_W-1:0]        adj_ra1;
    logic [ADDR_W-1:0]        adj_ra2;
    logic                     cap_we;
    logic [ADDR_W-1:0]        cap_wa;
    logic [STORE_W-1:0]       cap_wd;
    logic                     flow_we;
    logic [ADDR_W-1:0]        flow_wa;
    logic [FLOW_W-1:0]        flow_wd;
    logic                     adj_we;
    logic [ADDR_W-1:0]        adj_wa;
    logic                     adj_wd;
    logic [STORE_W:0]         cap_sum;
    logic signed [RES_W-1:0]  res;
    logic                     edge_ok;
    logic                     push;
    logic signed [LOW_W-1:0]  flow_ext;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        if (r_node_count < NUM_W'(2)) begin
            sink = IDX_W'(1);
        end else if (r_node_count > NUM_W'(MAX_NODES)) begin
            sink = IDX_W'(MAX_NODES - 1);
        end else begin
            sink = IDX_W'(r_node_count - NUM_W'(1));
        end
    end

    assign res      = RES_W'($signed({1'b0, r_cap_rd})) - RES_W'(r_flow_rd);
    assign edge_ok  = (r_adj_rd1 | r_adj_rd2) && (res > 0);
    assign push     = (i_cmd.op == OP_S_CHK) && edge_ok && !r_seen[r_x];
    assign cap_sum  = {1'b0, r_cap_rd} + (STORE_W + 1)'(r_cap_in);
    assign flow_ext = LOW_W'(r_flow_rd);
    assign acc_next = r_acc + ACC_W'(r_flow_rd);

    // read and write address selection
    always_comb begin
        cap_ra  = {r_u, r_x};
        flow_ra = {r_u, r_x};
        adj_ra1 = {r_u, r_x};
        adj_ra2 = {r_x, r_u};
        cap_we  = 1'b0;
        cap_wa  = r_clr;
        cap_wd  = '0;
        flow_we = 1'b0;
        flow_wa = r_clr;
        flow_wd = '0;
        adj_we  = 1'b0;
        adj_wa  = r_clr;
        adj_wd  = 1'b0;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                cap_we  = 1'b1;
                flow_we = 1'b1;
                adj_we  = 1'b1;
            end
            OP_LD_RD: begin
                cap_ra = {r_a, r_b};
            end
            OP_LD_WR: begin
                cap_we = r_ok;
                cap_wa = {r_a, r_b};
                cap_wd = cap_sum[STORE_W] ? STORE_MAX : cap_sum[STORE_W-1:0];
                adj_we = r_ok;
                adj_wa = {r_a, r_b};
                adj_wd = 1'b1;
            end
            OP_A_RD, OP_SUM_RD: begin
                cap_ra  = {r_x, sink};
                flow_ra = {r_x, sink};
                adj_ra1 = {r_x, sink};
                adj_ra2 = {sink, r_x};
            end
            OP_P_RD, OP_U_RD: begin
                cap_ra  = {r_par, r_cur};
                flow_ra = {r_par, r_cur};
            end
            OP_U_W1: begin
                flow_ra = {r_cur, r_par};
                flow_we = 1'b1;
                flow_wa = {r_par, r_cur};
                flow_wd = FLOW_W'(flow_ext + r_low);
            end
            OP_U_W2: begin
                flow_we = 1'b1;
                flow_wa = {r_cur, r_par};
                flow_wd = FLOW_W'(flow_ext - r_low);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cap_we) cap_mem[cap_wa] <= cap_wd;
        if (flow_we) flow_mem[flow_wa] <= flow_wd;
        if (adj_we) adj_mem[adj_wa] <= adj_wd;
        if (push) par_mem[r_x] <= r_u;
        if (i_cmd.op == OP_S_INIT) begin
            q_mem[0] <= '0;
        end else if (push) begin
            q_mem[r_tail[IDX_W-1:0]] <= r_x;
        end
        r_cap_rd  <= cap_mem[cap_ra];
        r_flow_rd <= flow_mem[flow_ra];
        r_adj_rd1 <= adj_mem[adj_ra1];
        r_adj_rd2 <= adj_mem[adj_ra2];
        r_par_rd  <= par_mem[r_par];
        r_q_rd    <= q_mem[r_head[IDX_W-1:0]];
    end

    // payload and path registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_ACCEPT: begin
                r_a      <= IDX_W'(i_edge_from - NUM_W'(1));
                r_b      <= IDX_W'(i_edge_to - NUM_W'(1));
                r_ok     <= (i_edge_from != '0) && (i_edge_from <= NUM_W'(MAX_NODES))
                         && (i_edge_to != '0) && (i_edge_to <= NUM_W'(MAX_NODES));
                r_cap_in <= i_capacity;
                r_last   <= i_last;
            end
            OP_S_U: begin
                r_u <= r_q_rd;
                r_x <= '0;
            end
            OP_S_CHK, OP_A_SKIP, OP_SUM_RD: begin
                r_x <= r_x + IDX_W'(1);
            end
            OP_A_INIT: begin
                r_x <= '0;
            end
            OP_SUM_INIT: begin
                r_x   <= '0;
                r_acc <= '0;
            end
            OP_SUM_ACC: begin
                r_acc <= acc_next;
            end
            OP_A_START: begin
                r_cur <= sink;
                r_par <= r_x;
                r_low <= BIG_BOUND;
            end
            OP_U_START: begin
                r_cur <= sink;
                r_par <= r_x;
            end
            OP_P_CHK: begin
                if (LOW_W'(res) < r_low) r_low <= LOW_W'(res);
                r_cur <= r_par;
            end
            OP_U_W2: begin
                r_cur <= r_par;
                if (r_par == '0) r_x <= r_x + IDX_W'(1);
            end
            OP_P_PAR, OP_U_PAR: begin
                r_par <= r_par_rd;
            end
            OP_EMIT: begin
                if (r_acc < 0) begin
                    r_max_flow <= '0;
                end else if (r_acc > ACC_W'(OUT_MAX)) begin
                    r_max_flow <= OUT_MAX;
                end else begin
                    r_max_flow <= OUT_W'(r_acc);
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NUM_W'(2);
            r_clr        <= '0;
            r_seen       <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_node_count <= i_cfg_wr_data;
            if (i_cmd.op == OP_CLEAR) r_clr <= r_clr + ADDR_W'(1);
            if (i_cmd.op == OP_S_INIT) begin
                r_seen <= MAX_NODES'(1);
                r_head <= '0;
                r_tail <= NUM_W'(1);
            end else begin
                if (push) begin
                    r_seen[r_x] <= 1'b1;
                    r_tail      <= r_tail + NUM_W'(1);
                end
                if (i_cmd.op == OP_S_POP) r_head <= r_head + NUM_W'(1);
            end
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last  = &r_clr;
    assign o_stat.last      = r_last;
    assign o_stat.q_empty   = r_head == r_tail;
    assign o_stat.sink_seen = r_seen[sink];
    assign o_stat.x_end     = r_x == sink;
    assign o_stat.x_seen    = r_seen[r_x];
    assign o_stat.edge_ok   = edge_ok;
    assign o_stat.par_src   = r_par == '0;
    assign o_stat.out_busy  = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_max_flow  = r_max_flow;

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= NUM_W'(MAX_NODES))
        else $error("search queue overrun");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("search queue read past write");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |=> r_out_valid)
        else $error("result not presented after emit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |-> !r_out_valid)
        else $error("result overwritten while pending");

endmodule
`default_nettype wire

FILE: rtl/max_flow_bfs_augment_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// max_flow_bfs_augment_core
// breadth-first augmenting-path maximum flow over a loaded edge list
// ---------------------------------------------------------------------------
// each edge request is a read-modify-write of the capacity store
// after the last edge: each search scans every node in use for each dequeued
// node, each augment walks its path twice (bottleneck, then flow update), and the
// final sum reads the flow into the sink from every other node in use
// after reset and after each result a clearing pass over all 4096 store entries
// runs before the next edge request is taken; reset is synchronous, active low
module max_flow_bfs_augment_core import mfbfs_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [NUM_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [NUM_W-1:0]     i_edge_from,
    input  wire logic [NUM_W-1:0]     i_edge_to,
    input  wire logic [CAP_WIDTH-1:0] i_capacity,
    input  wire logic                 i_last,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [OUT_W-1:0]          o_max_flow
);

    t_cmd  cmd;
    t_stat stat;

    mfbfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mfbfs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_edge_from   (i_edge_from),
        .i_edge_to     (i_edge_to),
        .i_capacity    (i_capacity),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_max_flow    (o_max_flow)
    );

endmodule
`default_nettype wire
